FILE: hdl/pit_pkg.sv
// ----------------------------------------------------------------------------
// pit_pkg
// Shared widths, register indexes and types of the point-in-triangle classifier.
// ----------------------------------------------------------------------------
package pit_pkg;

  localparam int unsigned COORD_WIDTH = 16;
  localparam int unsigned DIFF_W      = COORD_WIDTH + 1;
  localparam int unsigned PROD_W      = 2 * DIFF_W;
  localparam int unsigned CROSS_W     = PROD_W + 1;
  localparam int unsigned SUM_W       = CROSS_W + 2;

  localparam int unsigned IN_TDATA_W  = ((2 * COORD_WIDTH + 7) / 8) * 8;
  localparam int unsigned NUM_FLAGS   = 5;
  localparam int unsigned OUT_TDATA_W = ((NUM_FLAGS + 7) / 8) * 8;

  localparam int unsigned NUM_REGS    = 6;
  localparam int unsigned CFG_IDX_W   = 3;

  localparam logic [CFG_IDX_W-1:0] REG_A_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_A_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_B_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_C_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_C_Y = 3'd5;

  typedef struct packed {
    logic zero;
    logic neg;
    logic on_seg;
    logic ray_hit;
  } edge_flags_t;

  typedef struct packed {
    logic degenerate;
    logic bary_inside;
    logic side_inside;
    logic ray_inside;
    logic on_boundary;
  } result_t;

endpackage

FILE: hdl/pit_edge.sv
// ----------------------------------------------------------------------------
// pit_edge
// Edge function of one directed edge against a point: cross product sign,
// on-segment test and rightward ray crossing.
// ----------------------------------------------------------------------------
module pit_edge
  import pit_pkg::*;
(
  input  logic signed [COORD_WIDTH-1:0] ax_i,
  input  logic signed [COORD_WIDTH-1:0] ay_i,
  input  logic signed [COORD_WIDTH-1:0] bx_i,
  input  logic signed [COORD_WIDTH-1:0] by_i,
  input  logic signed [COORD_WIDTH-1:0] px_i,
  input  logic signed [COORD_WIDTH-1:0] py_i,
  output logic signed [CROSS_W-1:0]     cross_o,
  output edge_flags_t                   flags_o
);

  logic signed [DIFF_W-1:0]  ex, ey, qx, qy, rx, ry;
  logic signed [PROD_W-1:0]  p_exqy, p_eyqx, p_qxrx, p_qyry;
  logic signed [CROSS_W-1:0] dot;
  logic                      straddle;
  logic                      upward;

  assign ex = DIFF_W'(bx_i) - DIFF_W'(ax_i);
  assign ey = DIFF_W'(by_i) - DIFF_W'(ay_i);
  assign qx = DIFF_W'(px_i) - DIFF_W'(ax_i);
  assign qy = DIFF_W'(py_i) - DIFF_W'(ay_i);
  assign rx = DIFF_W'(px_i) - DIFF_W'(bx_i);
  assign ry = DIFF_W'(py_i) - DIFF_W'(by_i);

  assign p_exqy = PROD_W'(ex) * PROD_W'(qy);
  assign p_eyqx = PROD_W'(ey) * PROD_W'(qx);
  assign p_qxrx = PROD_W'(qx) * PROD_W'(rx);
  assign p_qyry = PROD_W'(qy) * PROD_W'(ry);

  assign cross_o = CROSS_W'(p_exqy) - CROSS_W'(p_eyqx);
  assign dot     = CROSS_W'(p_qxrx) + CROSS_W'(p_qyry);

  assign straddle = (ay_i > py_i) != (by_i > py_i);
  assign upward   = by_i > ay_i;

  always_comb begin
    flags_o.zero    = (cross_o == '0);
    flags_o.neg     = cross_o[CROSS_W-1];
    flags_o.on_seg  = flags_o.zero && (dot[CROSS_W-1] || (dot == '0));
    flags_o.ray_hit = straddle &&
                      (upward ? (!flags_o.neg && !flags_o.zero) : flags_o.neg);
  end

endmodule

FILE: hdl/point_in_triangle_classifier_top.sv
// ----------------------------------------------------------------------------
// point_in_triangle_classifier_top
// Classifies query points against a configured triangle: on-edge, ray parity,
// same-side and barycentric verdicts plus a degenerate-triangle flag.
// ----------------------------------------------------------------------------
//  channel   dir  tdata fields (lsb first)
//  s_axis    in   point_x, point_y
//  m_axis    out  on_boundary, ray_inside, side_inside, bary_inside, degenerate
//  cfg       in   index 0..5: a_x, a_y, b_x, b_y, c_x, c_y
//
//  One point per cycle while s_axis_tready is high. The edge products of a
//  point are evaluated between the input and result registers; the triangle
//  determinant is registered in the cycle after a write.
//  s_axis_tready drops only while both registers hold data and m_axis stalls.
//  Reset clears the vertices to zero and empties both registers.
// ----------------------------------------------------------------------------
module point_in_triangle_classifier_top
  import pit_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // point_x, point_y
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // on_boundary, ray_inside,
                                                // side_inside, bary_inside,
                                                // degenerate, zero fill
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [COORD_WIDTH-1:0] cfg_data_i
);

  logic signed [COORD_WIDTH-1:0] vert_q [NUM_REGS];
  logic signed [CROSS_W-1:0]     det_q, det_d;
  logic                          det_zero_q, det_neg_q;
  edge_flags_t                   det_flags;

  logic                          in_valid_q;
  logic signed [COORD_WIDTH-1:0] px_q, py_q;
  logic                          out_valid_q;
  result_t                       out_q, out_d;
  logic                          adv_out;
  logic                          take_in;

  logic signed [CROSS_W-1:0]     cr [3];
  edge_flags_t                   ef [3];
  logic signed [SUM_W-1:0]       bary_sum;

  // hold vertex registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) vert_q[i] <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_A_X: vert_q[0] <= cfg_data_i;
        REG_A_Y: vert_q[1] <= cfg_data_i;
        REG_B_X: vert_q[2] <= cfg_data_i;
        REG_B_Y: vert_q[3] <= cfg_data_i;
        REG_C_X: vert_q[4] <= cfg_data_i;
        REG_C_Y: vert_q[5] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  pit_edge u_det (
    .ax_i   (vert_q[0]),
    .ay_i   (vert_q[1]),
    .bx_i   (vert_q[2]),
    .by_i   (vert_q[3]),
    .px_i   (vert_q[4]),
    .py_i   (vert_q[5]),
    .cross_o(det_d),
    .flags_o(det_flags)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      det_q      <= '0;
      det_zero_q <= 1'b1;
      det_neg_q  <= 1'b0;
    end else begin
      det_q      <= det_d;
      det_zero_q <= det_flags.zero;
      det_neg_q  <= det_flags.neg;
    end
  end

  // handshake
  assign adv_out       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || adv_out;
  assign take_in       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) in_valid_q <= s_axis_tvalid;
      if (adv_out) out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_in) begin
      px_q <= s_axis_tdata[COORD_WIDTH-1:0];
      py_q <= s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
    end
    if (adv_out && in_valid_q) out_q <= out_d;
  end

  // edges AB, BC, CA against the point
  for (genvar e = 0; e < 3; e++) begin : g_edge
    pit_edge u_edge (
      .ax_i   (vert_q[2*e]),
      .ay_i   (vert_q[2*e+1]),
      .bx_i   (vert_q[(2*e+2)%(2*3)]),
      .by_i   (vert_q[(2*e+3)%(2*3)]),
      .px_i   (px_q),
      .py_i   (py_q),
      .cross_o(cr[e]),
      .flags_o(ef[e])
    );
  end

  assign bary_sum = SUM_W'(cr[2]) + SUM_W'(cr[0]) - SUM_W'(det_q);

  always_comb begin
    out_d.on_boundary = ef[0].on_seg || ef[1].on_seg || ef[2].on_seg;
    out_d.ray_inside  = ef[0].ray_hit ^ ef[1].ray_hit ^ ef[2].ray_hit;
    out_d.side_inside =
        (!ef[0].zero && !ef[1].zero && !ef[2].zero) &&
        ((ef[0].neg && ef[1].neg && ef[2].neg) ||
         (!ef[0].neg && !ef[1].neg && !ef[2].neg));
    out_d.degenerate  = det_zero_q;
    if (det_zero_q) begin
      out_d.bary_inside = 1'b0;
    end else if (det_neg_q) begin
      out_d.bary_inside = ef[2].neg && ef[0].neg &&
                          !bary_sum[SUM_W-1] && (bary_sum != '0);
    end else begin
      out_d.bary_inside = !ef[2].neg && !ef[2].zero &&
                          !ef[0].neg && !ef[0].zero && bary_sum[SUM_W-1];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W - NUM_FLAGS){1'b0}}, out_q};

endmodule
